/* sv/punycode_label_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Punycode label encoder
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef PUNYCODE_LABEL_ENCODER_TOP_ASSERT_SVH
`define PUNYCODE_LABEL_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication
`define PCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Types, constants and helpers shared by the Punycode label encoder.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int CP_W    = 21;
  localparam int CHAR_W  = 7;
  localparam int DELTA_W = 32;
  localparam int DIV_W   = 10;
  localparam int BIAS_W  = 12;
  localparam int K_W     = 10;
  localparam int RCP_W   = 33;

  localparam logic [CP_W-1:0]   CP_LIMIT  = 21'h110000;
  localparam logic [CP_W-1:0]   BASIC_MAX = 21'd127;
  localparam logic [CP_W-1:0]   N_INIT    = 21'd127;
  localparam logic [DIV_W-1:0]  SKEW      = 10'd38;
  localparam logic [DELTA_W-1:0] DELTA_BIG = 32'd455;
  localparam logic [K_W-1:0]    K_STEP    = 10'd36;
  localparam logic [CHAR_W-1:0] CHAR_DASH = 7'h2D;

  // Reciprocals for the constant divisions (exact for any 32-bit dividend)
  localparam logic [RCP_W-1:0]  RCP_DAMP    = 33'd6282923588;  // ceil(2^42 / 700)
  localparam int                RCP_DAMP_SH = 42;
  localparam logic [RCP_W-1:0]  RCP_35      = 33'd7853654485;  // ceil(2^38 / 35)
  localparam int                RCP_35_SH   = 38;

  localparam logic signed [BIAS_W-1:0] BIAS_INIT = -12'sd72;
  localparam logic signed [BIAS_W-1:0] BIAS_STEP = 12'sd36;
  localparam logic signed [BIAS_W-1:0] BIAS_TMIN = 12'sd1;
  localparam logic signed [BIAS_W-1:0] BIAS_TMAX = 12'sd26;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EMIT_DASH,
    OP_INIT,
    OP_MIN_INIT,
    OP_MIN_STEP,
    OP_MUL,
    OP_ADD_PROD,
    OP_SCAN_STEP,
    OP_Q_LOAD,
    OP_T_STEP,
    OP_Q_SUB,
    OP_DIV_Q,
    OP_EMIT_REM,
    OP_EMIT_Q,
    OP_DAMP,
    OP_DIV_DONE,
    OP_BOOST_LD,
    OP_DIV_35,
    OP_DIV_SKEW,
    OP_SKEW_LD,
    OP_NEXT,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DASH,
    S_INIT,
    S_OUTER,
    S_MIN,
    S_MIN_CHK,
    S_ADD,
    S_SCAN,
    S_T,
    S_CMP,
    S_QDIV,
    S_QWAIT,
    S_EMIT_REM,
    S_EMIT_Q,
    S_DAMP,
    S_BOOST,
    S_BOOST_W,
    S_LOOP,
    S_SKEW_W,
    S_OUTER_END,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_ok;
    logic basic_any;
    logic all_done;
    logic idx_last;
    logic m_none;
    logic c_eq_m;
    logic q_lt_t;
    logic delta_big;
    logic div_done;
    logic div_busy;
  } dp_stat_t;

  // Base-36 digit to ASCII: 0..25 -> a..z, 26..35 -> 0..9
  function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 6'd26) r = 7'd97 + CHAR_W'(d);
    else           r = 7'd22 + CHAR_W'(d);
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] lower_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    if (c >= 7'd65 && c <= 7'd90) r = c + 7'd32;
    else                          r = c;
    return r;
  endfunction

endpackage

/* sv/pce_stream_if.sv */
// ----------------------------------------------------------------------------
// pce_in_if / pce_out_if
// Valid/ready channels carrying code points in and ASCII characters out.
// ----------------------------------------------------------------------------
interface pce_in_if;
  import pce_pkg::*;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic              last_in_label;
  modport source (output valid, output code_point, output last_in_label, input ready);
  modport sink   (input valid, input code_point, input last_in_label, output ready);
endinterface

interface pce_out_if;
  import pce_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              end_of_label;
  logic              overflow;
  modport source (output valid, output ascii_char, output end_of_label, output overflow,
                  input ready);
  modport sink   (input valid, input ascii_char, input end_of_label, input overflow,
                  output ready);
endinterface

/* sv/pce_div.sv */
// ----------------------------------------------------------------------------
// pce_div
// Restoring divider, one quotient bit per cycle, shared by the digit, boost and skew divisions.
// ----------------------------------------------------------------------------
module pce_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pce_pkg::DELTA_W-1:0]  dividend_i,
  input  logic [pce_pkg::DIV_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [pce_pkg::DELTA_W-1:0]  quot_o,
  output logic [pce_pkg::DIV_W-1:0]    rem_o
);
  import pce_pkg::*;

  localparam int CNT_W = $clog2(DELTA_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DELTA_W-1:0] quot_q, quot_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   dvs_q, dvs_d;
  logic [DIV_W:0]     trial;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  // One shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[DELTA_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DELTA_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DIV_W'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[DELTA_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DIV_W-1:0];
        quot_d = {quot_q[DELTA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* sv/pce_dp.sv */
// ----------------------------------------------------------------------------
// pce_dp
// Datapath: code point store, counters, delta/bias registers, output stage.
// ----------------------------------------------------------------------------
module pce_dp #(
  parameter int LABEL_MAX = 64,
  parameter int OUT_MAX   = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pce_pkg::dp_cmd_t            cmd_i,
  output pce_pkg::dp_stat_t           stat_o,
  input  logic [pce_pkg::CP_W-1:0]    code_point_i,
  input  logic                        last_in_label_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pce_pkg::CHAR_W-1:0]  ascii_char_o,
  output logic                        end_of_label_o,
  output logic                        overflow_o
);
  import pce_pkg::*;

  localparam int IW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam int OW = $clog2(OUT_MAX + 1);

  // Control state
  logic [CW-1:0]     code_cnt_q, code_cnt_d;
  logic [CW-1:0]     basic_cnt_q, basic_cnt_d;
  logic [OW-1:0]     out_cnt_q, out_cnt_d;
  logic              ovf_q, ovf_d;
  logic              hold_v_q, hold_v_d;
  logic              out_v_q, out_v_d;

  // Payload state
  logic [CHAR_W-1:0] hold_ch_q, hold_ch_d;
  logic [CHAR_W-1:0] out_ch_q, out_ch_d;
  logic              out_eol_q, out_eol_d;
  logic              out_ovf_q, out_ovf_d;
  logic [CP_W-1:0]   n_q, n_d;
  logic [CP_W-1:0]   m_q, m_d;
  logic [DELTA_W-1:0] delta_q, delta_d;
  logic [DELTA_W-1:0] prod_q, prod_d;
  logic [DELTA_W-1:0] q_q, q_d;
  logic signed [BIAS_W-1:0] bias_q, bias_d;
  logic              first_q, first_d;
  logic [CW-1:0]     done_q, done_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [4:0]        t_q, t_d;
  logic [K_W-1:0]    k_q, k_d;

  // Code point store
  logic [CP_W-1:0]   mem_q [LABEL_MAX];
  logic [CP_W-1:0]   rdata_q;
  logic              wr_en;

  // Emit and push helpers
  logic              emit_req, emit_fin;
  logic [CHAR_W-1:0] emit_ch;
  logic              push;
  logic [CHAR_W-1:0] push_ch;
  logic              push_eol, push_ovf;
  logic              out_free, idx_last;

  // Divider hookup
  logic               div_start, div_busy, div_done;
  logic [DELTA_W-1:0] div_dvd, div_quot;
  logic [DIV_W-1:0]   div_dvs, div_rem;

  logic [CP_W-1:0]    gap;
  logic [CW:0]        mult;
  logic signed [BIAS_W-1:0] bias_nx;
  logic [K_W-1:0]     k_sum;

  // Reciprocal multiply for the divisions by 700 and 35
  logic [RCP_W-1:0]         rcp_mul;
  logic [DELTA_W+RCP_W-1:0] rcp_prod;
  logic [DELTA_W-1:0]       rcp_quot;

  pce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[code_cnt_q[IW-1:0]] <= code_point_i;
    rdata_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_cnt_q  <= '0;
      basic_cnt_q <= '0;
      out_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      code_cnt_q  <= code_cnt_d;
      basic_cnt_q <= basic_cnt_d;
      out_cnt_q   <= out_cnt_d;
      ovf_q       <= ovf_d;
      hold_v_q    <= hold_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_ch_q <= hold_ch_d;
    out_ch_q  <= out_ch_d;
    out_eol_q <= out_eol_d;
    out_ovf_q <= out_ovf_d;
    n_q       <= n_d;
    m_q       <= m_d;
    delta_q   <= delta_d;
    prod_q    <= prod_d;
    q_q       <= q_d;
    bias_q    <= bias_d;
    first_q   <= first_d;
    done_q    <= done_d;
    idx_q     <= idx_d;
    t_q       <= t_d;
    k_q       <= k_d;
  end

  assign out_free = !out_v_q || out_ready_i;
  assign idx_last = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(code_cnt_q);
  assign gap      = m_q - n_q - CP_W'(1);
  assign mult     = (CW+1)'(done_q) + (CW+1)'(1);
  assign bias_nx  = bias_q + BIAS_STEP;
  assign k_sum    = k_q + div_quot[K_W-1:0];

  // First damping divides by 700, every later reciprocal step by 35
  assign rcp_mul  = first_q ? RCP_DAMP : RCP_35;
  assign rcp_prod = (DELTA_W+RCP_W)'(delta_q) * (DELTA_W+RCP_W)'(rcp_mul);
  assign rcp_quot = first_q ? DELTA_W'(rcp_prod >> RCP_DAMP_SH)
                            : DELTA_W'(rcp_prod >> RCP_35_SH);

  // Operation decode
  always_comb begin
    code_cnt_d  = code_cnt_q;
    basic_cnt_d = basic_cnt_q;
    out_cnt_d   = out_cnt_q;
    ovf_d       = ovf_q;
    hold_v_d    = hold_v_q;
    hold_ch_d   = hold_ch_q;
    out_v_d     = out_v_q;
    out_ch_d    = out_ch_q;
    out_eol_d   = out_eol_q;
    out_ovf_d   = out_ovf_q;
    n_d         = n_q;
    m_d         = m_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    q_d         = q_q;
    bias_d      = bias_q;
    first_d     = first_q;
    done_d      = done_q;
    idx_d       = idx_q;
    t_d         = t_q;
    k_d         = k_q;
    wr_en       = 1'b0;
    emit_req    = 1'b0;
    emit_fin    = 1'b0;
    emit_ch     = '0;
    push        = 1'b0;
    push_ch     = '0;
    push_eol    = 1'b0;
    push_ovf    = 1'b0;
    div_start   = 1'b0;
    div_dvd     = delta_q;
    div_dvs     = '0;

    case (cmd_i.op)
      OP_ACCEPT: begin
        if (code_point_i >= CP_LIMIT || code_cnt_q >= CW'(LABEL_MAX)) begin
          ovf_d = 1'b1;
        end else begin
          wr_en      = 1'b1;
          code_cnt_d = code_cnt_q + CW'(1);
          if (code_point_i <= BASIC_MAX) begin
            basic_cnt_d = basic_cnt_q + CW'(1);
            emit_req    = 1'b1;
            emit_ch     = lower_char(code_point_i[CHAR_W-1:0]);
            emit_fin    = last_in_label_i;
          end
        end
      end
      OP_EMIT_DASH: begin
        emit_req = 1'b1;
        emit_ch  = CHAR_DASH;
        emit_fin = 1'b1;
      end
      OP_INIT: begin
        n_d     = N_INIT;
        delta_d = '0;
        bias_d  = BIAS_INIT;
        first_d = 1'b1;
        done_d  = basic_cnt_q;
      end
      OP_MIN_INIT: begin
        m_d   = CP_LIMIT;
        idx_d = '0;
      end
      OP_MIN_STEP: begin
        if (rdata_q > n_q && rdata_q < m_q) m_d = rdata_q;
        if (!idx_last) idx_d = idx_q + IW'(1);
      end
      OP_MUL: begin
        prod_d = DELTA_W'(gap) * DELTA_W'(mult);
      end
      OP_ADD_PROD: begin
        delta_d = delta_q + prod_q;
        idx_d   = '0;
      end
      OP_SCAN_STEP: begin
        if (rdata_q < m_q) delta_d = delta_q + DELTA_W'(1);
        if (!idx_last) idx_d = idx_q + IW'(1);
      end
      OP_Q_LOAD: begin
        q_d = delta_q;
      end
      OP_T_STEP: begin
        bias_d = bias_nx;
        if (bias_nx < BIAS_TMIN)      t_d = 5'd1;
        else if (bias_nx > BIAS_TMAX) t_d = 5'd26;
        else                          t_d = bias_nx[4:0];
      end
      OP_Q_SUB: begin
        q_d = q_q - DELTA_W'(t_q);
      end
      OP_DIV_Q: begin
        div_start = 1'b1;
        div_dvd   = q_q;
        div_dvs   = DIV_W'(6'd36 - 6'(t_q));
      end
      OP_EMIT_REM: begin
        emit_req = 1'b1;
        emit_fin = 1'b1;
        emit_ch  = digit_char(6'(t_q) + div_rem[5:0]);
        q_d      = div_quot;
      end
      OP_EMIT_Q: begin
        emit_req = 1'b1;
        emit_fin = 1'b1;
        emit_ch  = digit_char(q_q[5:0]);
      end
      OP_DAMP: begin
        done_d  = done_q + CW'(1);
        delta_d = first_q ? rcp_quot : (delta_q >> 1);
        first_d = 1'b0;
      end
      OP_DIV_DONE: begin
        div_start = 1'b1;
        div_dvs   = DIV_W'(done_q);
      end
      OP_BOOST_LD: begin
        delta_d = delta_q + div_quot;
        k_d     = '0;
      end
      OP_DIV_35: begin
        delta_d = rcp_quot;
        k_d     = k_q + K_STEP;
      end
      OP_DIV_SKEW: begin
        div_start = 1'b1;
        div_dvd   = DELTA_W'(delta_q[8:0]) * DELTA_W'(36);
        div_dvs   = DIV_W'(delta_q[8:0]) + SKEW;
      end
      OP_SKEW_LD: begin
        bias_d  = -$signed({{(BIAS_W-K_W){1'b0}}, k_sum});
        delta_d = '0;
        if (!idx_last) idx_d = idx_q + IW'(1);
      end
      OP_NEXT: begin
        delta_d = delta_q + DELTA_W'(1);
        n_d     = m_q;
      end
      OP_FINISH: begin
        push        = 1'b1;
        push_ch     = hold_v_q ? hold_ch_q : '0;
        push_eol    = 1'b1;
        push_ovf    = hold_v_q ? ovf_q : 1'b1;
        code_cnt_d  = '0;
        basic_cnt_d = '0;
        out_cnt_d   = '0;
        ovf_d       = 1'b0;
        hold_v_d    = 1'b0;
      end
      default: begin
      end
    endcase

    // Character emission: direct for a mid-label beat, held back in the final phase
    if (emit_req) begin
      if (out_cnt_q >= OW'(OUT_MAX)) begin
        ovf_d = 1'b1;
      end else begin
        out_cnt_d = out_cnt_q + OW'(1);
        if (!emit_fin) begin
          push    = 1'b1;
          push_ch = emit_ch;
        end else begin
          if (hold_v_q) begin
            push    = 1'b1;
            push_ch = hold_ch_q;
          end
          hold_ch_d = emit_ch;
          hold_v_d  = 1'b1;
        end
      end
    end

    // Output register
    if (push) begin
      out_v_d   = 1'b1;
      out_ch_d  = push_ch;
      out_eol_d = push_eol;
      out_ovf_d = push_ovf;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.out_free  = out_free;
    stat_o.emit_ok   = !hold_v_q || out_free;
    stat_o.basic_any = basic_cnt_q != '0;
    stat_o.all_done  = done_q >= code_cnt_q;
    stat_o.idx_last  = idx_last;
    stat_o.m_none    = m_q == CP_LIMIT;
    stat_o.c_eq_m    = rdata_q == m_q;
    stat_o.q_lt_t    = q_q < DELTA_W'(t_q);
    stat_o.delta_big = delta_q > DELTA_BIG;
    stat_o.div_done  = div_done;
    stat_o.div_busy  = div_busy;
  end

  assign out_valid_o    = out_v_q;
  assign ascii_char_o   = out_ch_q;
  assign end_of_label_o = out_eol_q;
  assign overflow_o     = out_ovf_q;

endmodule

/* sv/pce_ctrl.sv */
// ----------------------------------------------------------------------------
// pce_ctrl
// Sequencer: input intake, minimum scans, digit generation, bias adaptation.
// ----------------------------------------------------------------------------
module pce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output pce_pkg::dp_cmd_t  cmd_o,
  input  pce_pkg::dp_stat_t stat_i
);
  import pce_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.op = OP_ACCEPT;
          if (in_last_i) state_d = S_DASH;
        end
      end
      S_DASH: begin
        if (!stat_i.basic_any) begin
          state_d = S_INIT;
        end else if (stat_i.emit_ok) begin
          cmd_o.op = OP_EMIT_DASH;
          state_d  = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_OUTER;
      end
      S_OUTER: begin
        if (stat_i.all_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = OP_MIN_INIT;
          state_d  = S_MIN;
        end
      end
      S_MIN: begin
        cmd_o.op = OP_MIN_STEP;
        if (stat_i.idx_last) state_d = S_MIN_CHK;
      end
      S_MIN_CHK: begin
        if (stat_i.m_none) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = OP_MUL;
          state_d  = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.op = OP_ADD_PROD;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.c_eq_m) begin
          cmd_o.op = OP_Q_LOAD;
          state_d  = S_T;
        end else begin
          cmd_o.op = OP_SCAN_STEP;
          if (stat_i.idx_last) state_d = S_OUTER_END;
        end
      end
      S_T: begin
        cmd_o.op = OP_T_STEP;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (stat_i.q_lt_t) begin
          state_d = S_EMIT_Q;
        end else begin
          cmd_o.op = OP_Q_SUB;
          state_d  = S_QDIV;
        end
      end
      S_QDIV: begin
        cmd_o.op = OP_DIV_Q;
        state_d  = S_QWAIT;
      end
      S_QWAIT: begin
        if (stat_i.div_done) state_d = S_EMIT_REM;
      end
      S_EMIT_REM: begin
        if (stat_i.emit_ok) begin
          cmd_o.op = OP_EMIT_REM;
          state_d  = S_T;
        end
      end
      S_EMIT_Q: begin
        if (stat_i.emit_ok) begin
          cmd_o.op = OP_EMIT_Q;
          state_d  = S_DAMP;
        end
      end
      S_DAMP: begin
        cmd_o.op = OP_DAMP;
        state_d  = S_BOOST;
      end
      S_BOOST: begin
        cmd_o.op = OP_DIV_DONE;
        state_d  = S_BOOST_W;
      end
      S_BOOST_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_BOOST_LD;
          state_d  = S_LOOP;
        end
      end
      // One reciprocal step per cycle while delta is large
      S_LOOP: begin
        if (stat_i.delta_big) begin
          cmd_o.op = OP_DIV_35;
        end else begin
          cmd_o.op = OP_DIV_SKEW;
          state_d  = S_SKEW_W;
        end
      end
      S_SKEW_W: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_SKEW_LD;
          state_d  = stat_i.idx_last ? S_OUTER_END : S_SCAN;
        end
      end
      S_OUTER_END: begin
        cmd_o.op = OP_NEXT;
        state_d  = S_OUTER;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/punycode_label_encoder_top.sv */
// ----------------------------------------------------------------------------
// punycode_label_encoder_top
// Punycode label encoder: code points in, ASCII characters out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one code point per beat with last_in_label on the final one.
//   out_o carries one ASCII character per beat; end_of_label marks the final
//   character of a label and overflow on it reports dropped input or
//   truncated output. A label that yields nothing gives one beat with
//   ascii_char 0, end_of_label 1 and overflow 1.
// Sequence:
//   A code point that is not the last is taken in S_IDLE; a basic one is
//   on out_o the next cycle. The last code point starts the encoder: per
//   distinct non-basic value one scan of the store for the minimum and one
//   counting scan over all stored code points, plus a division for each
//   digit that needs one and, for the bias update of each encoded code
//   point, two divisions and up to four reciprocal steps. The store has a
//   single read port and the divider produces one quotient bit per cycle.
// Reset / stall:
//   Reset empties the label. When out_o stalls, in_i is not ready, the
//   encoder halts at a push; one finished beat waits in the output register.
// ----------------------------------------------------------------------------
module punycode_label_encoder_top #(
  parameter int LABEL_MAX = 64,
  parameter int OUT_MAX   = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pce_in_if.sink           in_i,
  pce_out_if.source        out_o
);
  import pce_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     div_cmd;
  logic     marker_beat;

  pce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_in_label),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  pce_dp #(
    .LABEL_MAX (LABEL_MAX),
    .OUT_MAX   (OUT_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .code_point_i    (in_i.code_point),
    .last_in_label_i (in_i.last_in_label),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .ascii_char_o    (out_o.ascii_char),
    .end_of_label_o  (out_o.end_of_label),
    .overflow_o      (out_o.overflow)
  );

  // Assertions
  assign div_cmd     = cmd.op == OP_DIV_Q || cmd.op == OP_DIV_DONE || cmd.op == OP_DIV_SKEW;
  assign marker_beat = out_o.valid && out_o.end_of_label && out_o.ascii_char == '0;

  `include "punycode_label_encoder_top_assert.svh"

  `PCE_ASSERT_IMP(a_in_needs_out_room, in_i.ready, !out_o.valid || out_o.ready, "no out room")
  `PCE_ASSERT_IMP(a_div_start_idle, div_cmd, !stat.div_busy, "divider restarted while busy")
  `PCE_ASSERT_NXT(a_div_runs, div_cmd, stat.div_busy, "divider did not start")
  `PCE_ASSERT_IMP(a_marker_flags, marker_beat, out_o.overflow, "empty label end without overflow")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the Punycode label encoder against an in-bench encoder: code points
// go in as labels, every output character is compared with the predicted one.
// ----------------------------------------------------------------------------

typedef struct {
  logic [6:0] ch;
  bit         eol;
  bit         ovf;
} puny_char_t;

// Predicts the characters of each label and checks the block's output
class puny_scoreboard;
  localparam int LBL_MAX = 64;
  localparam int OUT_LIM = 64;

  puny_char_t  pending_q[$];
  puny_char_t  label_q[$];
  logic [20:0] cps[LBL_MAX];
  int          n_cps;
  int          n_basic;
  int          n_out;
  bit          dropped;
  int          mismatches;

  function void clear_label();
    n_cps   = 0;
    n_basic = 0;
    n_out   = 0;
    dropped = 0;
  endfunction

  function void put_char(logic [6:0] ch);
    puny_char_t c;
    if (n_out >= OUT_LIM) begin
      dropped = 1;
      return;
    end
    c.ch  = ch;
    c.eol = 0;
    c.ovf = 0;
    label_q = {label_q, c};
    n_out++;
  endfunction

  function void put_digit(longint unsigned d);
    if (d < 26) put_char(7'(97 + d));
    else        put_char(7'(48 + d - 26));
  endfunction

  // Variable-length deltas of the non-basic code points, bias kept negated
  function void encode_rest();
    logic [20:0]     n, m, c;
    longint unsigned delta, q, t, k;
    longint          bias, ts;
    bit              first;
    int              done;
    n = 21'd127;
    delta = 0;
    bias = -72;
    first = 1;
    done = n_basic;
    while (done < n_cps) begin
      m = 21'h110000;
      for (int i = 0; i < n_cps; i++)
        if (cps[i] > n && cps[i] < m) m = cps[i];
      if (m == 21'h110000) break;
      delta += longint'(m - n - 1) * longint'(done + 1);
      for (int i = 0; i < n_cps; i++) begin
        c = cps[i];
        if (c < m) delta++;
        if (c == m) begin
          q = delta;
          forever begin
            bias += 36;
            ts = bias < 1 ? 1 : (bias > 26 ? 26 : bias);
            t = ts;
            if (q < t) begin
              put_digit(q);
              break;
            end
            q -= t;
            put_digit(t + q % (36 - t));
            q /= 36 - t;
          end
          done++;
          delta = first ? delta / 700 : delta / 2;
          first = 0;
          delta += delta / done;
          k = 0;
          while (delta > 455) begin
            delta /= 35;
            k += 36;
          end
          k += (36 * delta) / (delta + 38);
          bias = -longint'(k);
          delta = 0;
        end
      end
      delta++;
      n = m;
    end
  endfunction

  // Accepted input beat: work out the characters it causes
  function void note_code_point(logic [20:0] cp, bit last);
    logic [6:0] ch;
    puny_char_t c;
    label_q.delete();
    if (cp >= 21'h110000 || n_cps >= LBL_MAX) begin
      dropped = 1;
    end else begin
      cps[n_cps++] = cp;
      if (cp <= 127) begin
        ch = cp[6:0];
        if (ch >= 7'd65 && ch <= 7'd90) ch += 7'd32;
        n_basic++;
        put_char(ch);
      end
    end
    if (last) begin
      if (n_basic > 0) put_char(7'h2D);
      encode_rest();
      if (label_q.size() == 0) begin
        c.ch  = 0;
        c.eol = 1;
        c.ovf = 1;
        label_q = {label_q, c};
      end else begin
        label_q[$].eol = 1;
        label_q[$].ovf = dropped;
      end
      clear_label();
    end
    foreach (label_q[i]) pending_q = {pending_q, label_q[i]};
  endfunction

  // Accepted output beat: compare with the oldest prediction
  function void check_char(logic [6:0] ch, logic eol, logic ovf);
    puny_char_t e;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected char %h eol %b ovf %b", ch, eol, ovf);
      return;
    end
    e = pending_q.pop_front();
    if (ch !== e.ch || eol !== e.eol || ovf !== e.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("char mismatch: exp %h/%b/%b got %h/%b/%b",
                 e.ch, e.eol, e.ovf, ch, eol, ovf);
    end
  endfunction
endclass

module tb;
  localparam int WATCHDOG = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pce_in_if  in_if();
  pce_out_if out_if();

  punycode_label_encoder_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  puny_scoreboard sb = new();
  bit             no_idle;
  bit             hold_req;
  int             n_sent;
  int             quiet_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.code_point <= '0;
    in_if.last_in_label <= 1'b0;
    out_if.ready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // One code point beat, with a random gap before it
  task automatic send_cp(logic [20:0] cp, bit last);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.code_point <= cp;
    in_if.last_in_label <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_code_point(cp, last);
    n_sent++;
  endtask

  task automatic send_label(logic [20:0] cps[$]);
    foreach (cps[i]) send_cp(cps[i], i == cps.size() - 1);
  endtask

  function automatic logic [20:0] rand_cp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return 21'($urandom_range(65, 90));
    if (sel < 40) return 21'($urandom_range(0, 127));
    if (sel < 75) return 21'($urandom_range(128, 700));
    if (sel < 90) return 21'($urandom_range(128, 21'h10FFFF));
    if (sel < 95) return ($urandom_range(1)) ? 21'h10FFFF : 21'h80;
    return 21'($urandom);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_char(out_if.ascii_char, out_if.end_of_label, out_if.overflow);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [20:0] lbl[$];
    logic [20:0] cp_pick;
    int          len;
    int          lbl_idx;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed labels
    send_label('{21'h41});
    send_label('{21'h0, 21'h7F, 21'h5A, 21'h61});
    send_label('{21'h80, 21'h10FFFF});
    send_label('{21'h110000});
    send_label('{21'h1FFFFF, 21'h42});
    send_label('{21'h62, 21'hFC, 21'h63, 21'hFC});
    send_label('{21'h4E2D, 21'h6587, 21'h2D});
    send_label('{21'h1F600});

    // Random labels
    lbl_idx = 0;
    while (n_sent < 404) begin
      lbl.delete();
      if (lbl_idx % 15 == 7) begin
        // Long label, mostly basic: output limit and full store
        len = $urandom_range(60, 70);
        repeat (len) begin
          cp_pick = ($urandom_range(9) == 0) ? 21'($urandom_range(128, 300))
                                             : 21'($urandom_range(0, 127));
          lbl = {lbl, cp_pick};
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          cp_pick = rand_cp();
          lbl = {lbl, cp_pick};
        end
      end
      if (lbl_idx == 10) hold_req = 1;
      if (lbl_idx == 20) begin
        in_if.valid <= 1'b0;
        wait (sb.pending_q.size() == 0);
      end
      no_idle = (lbl_idx >= 30 && lbl_idx < 45);
      send_label(lbl);
      lbl_idx++;
    end
    // One long label of non-basic repeats to fill the store
    lbl.delete();
    repeat (66) begin
      cp_pick = 21'($urandom_range(128, 140));
      lbl = {lbl, cp_pick};
    end
    send_label(lbl);
    in_if.valid <= 1'b0;

    wait (sb.pending_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
